@@ hw/rtl/cwrq_pkg.sv @@
package cwrq_pkg;

  localparam int NUM_IDS_DEF           = 4;
  localparam int QUEUE_DEPTH_DEF       = 8;
  localparam int MAX_PAYLOAD_BYTES_DEF = 64;
  localparam int NUM_ID_REGS           = 4;
  localparam int CMD_FIFO_DEPTH        = 2;

  localparam int ID_W       = 29;
  localparam int DLC_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int BYTES_W    = 7;
  localparam int DATA_W     = 64;
  localparam int SLOTS_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  localparam logic KIND_RX  = 1'b0;
  localparam logic KIND_POP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_SLOT_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_UNLISTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FIRST,
    BK_LOAD,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   can_id;
    logic              is_extended;
    logic [DLC_W-1:0]  dlc;
    logic [DATA_W-1:0] data_word;
    logic              beat_last;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    frame_id;
    logic               frame_extended;
    logic [DLC_W-1:0]   frame_dlc;
    logic [BYTES_W-1:0] byte_count;
    logic [DATA_W-1:0]  payload_word;
    logic               result_last;
  } out_item_t;

  typedef struct packed {
    logic [DLC_W-1:0] dlc;
    logic             ext;
    logic [ID_W-1:0]  id;
  } hdr_t;

  function automatic logic [BYTES_W-1:0] dlc_to_bytes(input logic [DLC_W-1:0] dlc);
    logic [BYTES_W-1:0] n;
    case (dlc)
      4'd9:    n = 7'd12;
      4'd10:   n = 7'd16;
      4'd11:   n = 7'd20;
      4'd12:   n = 7'd24;
      4'd13:   n = 7'd32;
      4'd14:   n = 7'd48;
      4'd15:   n = 7'd64;
      default: n = {3'b000, dlc};
    endcase
    return n;
  endfunction

endpackage

@@ hw/rtl/can_id_whitelist_rx_queues_unit.sv @@
// CAN FD receive queues with an identifier whitelist. A received frame beat is written
// straight into the header and payload memories of the queue that its identifier selects;
// frames whose identifier is not listed are dropped, and a full queue loses its oldest frame.
// A pop request is classified combinationally and placed in a two-entry command queue; an
// idle back end takes the command in the cycle after the request is accepted, reads the
// frame and returns it as one beat per payload word. The first beat is ready for transfer
// after the back end passes through BK_FIRST, and after each transfer that is not the last
// it passes through BK_LOAD before the next beat, set by the registered read of the payload
// memory. A pop that finds no frame or an unlisted identifier returns a single status beat
// in the cycle after the back end takes the command. Receive beats wait while a pop is queued
// or being returned, so a frame slot is never rewritten while it is read out; pops keep being
// taken until the command queue is full. No memory needs clearing after reset.
module can_id_whitelist_rx_queues_unit #(
  parameter int NUM_IDS           = cwrq_pkg::NUM_IDS_DEF,
  parameter int QUEUE_DEPTH       = cwrq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = cwrq_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cwrq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwrq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cwrq_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cwrq_pkg::out_item_t             out_data
);

  localparam int BEATS   = (MAX_PAYLOAD_BYTES + 7) / 8;
  localparam int ENTRIES = NUM_IDS * QUEUE_DEPTH;
  localparam int ENT_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAY_AW  = (ENTRIES * BEATS > 1) ? $clog2(ENTRIES * BEATS) : 1;
  localparam int BIDX_W  = $clog2(BEATS + 1);
  localparam int HDR_W   = BIDX_W + $bits(cwrq_pkg::hdr_t);
  localparam int CMD_W   = cwrq_pkg::STATUS_W + ENT_AW;

  logic                        back_busy;
  logic                        cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0]            cmd_wdata, cmd_rdata;
  logic                        hdr_we, hdr_re;
  logic [ENT_AW-1:0]           hdr_waddr, hdr_raddr;
  logic [HDR_W-1:0]            hdr_wdata, hdr_rdata;
  logic                        pay_we, pay_re;
  logic [PAY_AW-1:0]           pay_waddr, pay_raddr;
  logic [cwrq_pkg::DATA_W-1:0] pay_wdata, pay_rdata;

  cwrq_front #(
    .NUM_IDS           (NUM_IDS),
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .back_busy (back_busy),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_wdata),
    .cmd_full  (cmd_full),
    .hdr_we    (hdr_we),
    .hdr_waddr (hdr_waddr),
    .hdr_wdata (hdr_wdata),
    .pay_we    (pay_we),
    .pay_waddr (pay_waddr),
    .pay_wdata (pay_wdata)
  );

  cwrq_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (cwrq_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_wdata),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_rdata),
    .empty     (cmd_empty)
  );

  cwrq_ram #(
    .WIDTH (HDR_W),
    .DEPTH (ENTRIES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .re    (hdr_re),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  cwrq_ram #(
    .WIDTH (cwrq_pkg::DATA_W),
    .DEPTH (ENTRIES * BEATS)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  cwrq_back #(
    .NUM_IDS           (NUM_IDS),
    .QUEUE_DEPTH       (QUEUE_DEPTH),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .busy      (back_busy),
    .hdr_re    (hdr_re),
    .hdr_raddr (hdr_raddr),
    .hdr_rdata (hdr_rdata),
    .pay_re    (pay_re),
    .pay_raddr (pay_raddr),
    .pay_rdata (pay_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/cwrq_ram.sv @@
module cwrq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/cwrq_fifo.sv @@
module cwrq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

endmodule

@@ hw/rtl/cwrq_front.sv @@
module cwrq_front #(
  parameter int NUM_IDS           = cwrq_pkg::NUM_IDS_DEF,
  parameter int QUEUE_DEPTH       = cwrq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = cwrq_pkg::MAX_PAYLOAD_BYTES_DEF,
  localparam int BEATS   = (MAX_PAYLOAD_BYTES + 7) / 8,
  localparam int ENTRIES = NUM_IDS * QUEUE_DEPTH,
  localparam int ENT_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int PAY_AW  = (ENTRIES * BEATS > 1) ? $clog2(ENTRIES * BEATS) : 1,
  localparam int BIDX_W  = $clog2(BEATS + 1),
  localparam int HDR_W   = BIDX_W + $bits(cwrq_pkg::hdr_t),
  localparam int CMD_W   = cwrq_pkg::STATUS_W + ENT_AW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [cwrq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwrq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cwrq_pkg::in_item_t                 in_data,
  input  logic                               back_busy,
  output logic                               cmd_push,
  output logic [CMD_W-1:0]                   cmd_data,
  input  logic                               cmd_full,
  output logic                               hdr_we,
  output logic [ENT_AW-1:0]                  hdr_waddr,
  output logic [HDR_W-1:0]                   hdr_wdata,
  output logic                               pay_we,
  output logic [PAY_AW-1:0]                  pay_waddr,
  output logic [cwrq_pkg::DATA_W-1:0]        pay_wdata
);

  localparam int SLOT_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [cwrq_pkg::ID_W-1:0]    id_slot_r [cwrq_pkg::NUM_ID_REGS];
  logic [cwrq_pkg::SLOTS_W-1:0] slots_in_use_r;
  logic [PTR_W-1:0]             head_r [NUM_IDS];
  logic [FILL_W-1:0]            fill_r [NUM_IDS];
  logic                         in_frame_r, in_frame_nxt;
  logic                         match_vld_r, match_vld_nxt;
  logic [SLOT_W-1:0]            match_slot_r, match_slot_nxt;
  logic [BIDX_W-1:0]            beat_idx_r, beat_idx_nxt;
  logic [ENT_AW-1:0]            tail_entry_r, tail_entry_nxt;
  cwrq_pkg::hdr_t               hdr_r, hdr_nxt;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              accept, is_rx;
  logic [SLOT_W-1:0] cur_slot;
  logic [PTR_W-1:0]  head_cur, head_adv, head_rx, tail;
  logic [FILL_W-1:0] fill_cur, fill_rx, fill_base;
  logic [FILL_W:0]   tail_sum;
  logic              q_full;
  logic [ENT_AW-1:0] entry_new, cur_entry;
  cwrq_pkg::hdr_t    cur_hdr;
  logic              cur_match;
  logic [BIDX_W-1:0] cur_bidx;
  logic              head_we, fill_we;
  logic [PTR_W-1:0]  head_wd;
  logic [FILL_W-1:0] fill_wd;
  cwrq_pkg::status_t cmd_status;
  logic [ENT_AW-1:0] cmd_entry;

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (i < int'(slots_in_use_r) && id_slot_r[i] == in_data.can_id) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign is_rx    = (in_data.kind == cwrq_pkg::KIND_RX);
  assign in_stall = is_rx ? back_busy : cmd_full;
  assign accept   = in_valid && !in_stall;

  assign cur_slot = (is_rx && in_frame_r) ? match_slot_r : hit_slot;
  assign head_cur = head_r[cur_slot];
  assign fill_cur = fill_r[cur_slot];
  assign q_full   = (fill_cur >= FILL_W'(QUEUE_DEPTH));
  assign head_adv = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
  assign head_rx  = q_full ? head_adv : head_cur;
  assign fill_rx  = q_full ? FILL_W'(QUEUE_DEPTH - 1) : fill_cur;
  assign tail_sum = (FILL_W + 1)'(head_rx) + (FILL_W + 1)'(fill_rx);
  assign tail     = (tail_sum >= (FILL_W + 1)'(QUEUE_DEPTH)) ?
                    PTR_W'(tail_sum - (FILL_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign entry_new = ENT_AW'(hit_slot) * ENT_AW'(QUEUE_DEPTH) + ENT_AW'(tail);

  assign cur_match = in_frame_r ? match_vld_r : hit;
  assign cur_entry = in_frame_r ? tail_entry_r : entry_new;
  assign cur_bidx  = in_frame_r ? beat_idx_r : '0;
  assign fill_base = in_frame_r ? fill_cur : fill_rx;

  always_comb begin
    cur_hdr.dlc = in_data.dlc;
    cur_hdr.ext = in_data.is_extended;
    cur_hdr.id  = in_data.can_id;
    if (in_frame_r) begin
      cur_hdr = hdr_r;
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    match_vld_nxt  = match_vld_r;
    match_slot_nxt = match_slot_r;
    beat_idx_nxt   = beat_idx_r;
    tail_entry_nxt = tail_entry_r;
    hdr_nxt        = hdr_r;
    head_we        = 1'b0;
    head_wd        = head_adv;
    fill_we        = 1'b0;
    fill_wd        = fill_base;
    hdr_we         = 1'b0;
    pay_we         = 1'b0;
    cmd_push       = 1'b0;
    cmd_status     = cwrq_pkg::STATUS_OK;
    cmd_entry      = ENT_AW'(hit_slot) * ENT_AW'(QUEUE_DEPTH) + ENT_AW'(head_cur);
    if (accept && is_rx) begin
      if (!in_frame_r) begin
        match_vld_nxt  = hit;
        match_slot_nxt = hit_slot;
        tail_entry_nxt = entry_new;
        hdr_nxt        = cur_hdr;
        head_we        = hit && q_full;
        head_wd        = head_rx;
      end
      if (cur_match && cur_bidx < BIDX_W'(BEATS)) begin
        hdr_we       = 1'b1;
        pay_we       = 1'b1;
        beat_idx_nxt = cur_bidx + 1'b1;
      end else begin
        beat_idx_nxt = cur_bidx;
      end
      fill_we = cur_match;
      if (in_data.beat_last) begin
        in_frame_nxt = 1'b0;
        fill_wd      = fill_base + 1'b1;
      end else begin
        in_frame_nxt = 1'b1;
      end
    end else if (accept) begin
      cmd_push = 1'b1;
      if (!hit) begin
        cmd_status = cwrq_pkg::STATUS_UNLISTED;
      end else if (fill_cur == '0) begin
        cmd_status = cwrq_pkg::STATUS_EMPTY;
      end else begin
        head_we = 1'b1;
        fill_we = 1'b1;
        fill_wd = fill_cur - 1'b1;
      end
    end
  end

  assign cmd_data  = {cmd_status, cmd_entry};
  assign hdr_waddr = cur_entry;
  assign hdr_wdata = {BIDX_W'(cur_bidx + 1'b1), cur_hdr};
  assign pay_waddr = PAY_AW'(cur_entry) * PAY_AW'(BEATS) + PAY_AW'(cur_bidx);
  assign pay_wdata = in_data.data_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cwrq_pkg::NUM_ID_REGS; i++) begin
        id_slot_r[i] <= '0;
      end
      for (int i = 0; i < NUM_IDS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
      slots_in_use_r <= '0;
      in_frame_r     <= 1'b0;
      match_vld_r    <= 1'b0;
      match_slot_r   <= '0;
      beat_idx_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          cwrq_pkg::REG_ID_SLOT_0:    id_slot_r[0]   <= cfg_wdata;
          cwrq_pkg::REG_ID_SLOT_1:    id_slot_r[1]   <= cfg_wdata;
          cwrq_pkg::REG_ID_SLOT_2:    id_slot_r[2]   <= cfg_wdata;
          cwrq_pkg::REG_ID_SLOT_3:    id_slot_r[3]   <= cfg_wdata;
          cwrq_pkg::REG_SLOTS_IN_USE: slots_in_use_r <= cfg_wdata[cwrq_pkg::SLOTS_W-1:0];
          default: ;
        endcase
      end
      if (head_we) begin
        head_r[cur_slot] <= head_wd;
      end
      if (fill_we) begin
        fill_r[cur_slot] <= fill_wd;
      end
      in_frame_r   <= in_frame_nxt;
      match_vld_r  <= match_vld_nxt;
      match_slot_r <= match_slot_nxt;
      beat_idx_r   <= beat_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_entry_r <= tail_entry_nxt;
    hdr_r        <= hdr_nxt;
  end

endmodule

@@ hw/rtl/cwrq_back.sv @@
module cwrq_back #(
  parameter int NUM_IDS           = cwrq_pkg::NUM_IDS_DEF,
  parameter int QUEUE_DEPTH       = cwrq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD_BYTES = cwrq_pkg::MAX_PAYLOAD_BYTES_DEF,
  localparam int BEATS   = (MAX_PAYLOAD_BYTES + 7) / 8,
  localparam int ENTRIES = NUM_IDS * QUEUE_DEPTH,
  localparam int ENT_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int PAY_AW  = (ENTRIES * BEATS > 1) ? $clog2(ENTRIES * BEATS) : 1,
  localparam int BIDX_W  = $clog2(BEATS + 1),
  localparam int HDR_W   = BIDX_W + $bits(cwrq_pkg::hdr_t),
  localparam int CMD_W   = cwrq_pkg::STATUS_W + ENT_AW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  logic [CMD_W-1:0]            cmd_data,
  output logic                        cmd_pop,
  output logic                        busy,
  output logic                        hdr_re,
  output logic [ENT_AW-1:0]           hdr_raddr,
  input  logic [HDR_W-1:0]            hdr_rdata,
  output logic                        pay_re,
  output logic [PAY_AW-1:0]           pay_raddr,
  input  logic [cwrq_pkg::DATA_W-1:0] pay_rdata,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cwrq_pkg::out_item_t         out_data
);

  localparam int BEAT_W = (BEATS > 1) ? $clog2(BEATS) : 1;

  cwrq_pkg::back_state_t state_r, state_nxt;
  logic [ENT_AW-1:0]     entry_r, entry_nxt;
  logic [BEAT_W-1:0]     k_r, k_nxt;
  cwrq_pkg::hdr_t        hdr_r, hdr_nxt;
  logic [BIDX_W-1:0]     cnt_r, cnt_nxt;
  cwrq_pkg::out_item_t   out_r, out_nxt;

  cwrq_pkg::status_t           cmd_status;
  logic [ENT_AW-1:0]           cmd_entry;
  cwrq_pkg::hdr_t              cur_hdr;
  logic [BIDX_W-1:0]           cur_cnt;
  logic [cwrq_pkg::BYTES_W-1:0] nbytes_raw, nbytes;
  logic [7:0]                  nbeats_w;
  logic [BIDX_W-1:0]           nbeats;
  logic [cwrq_pkg::DATA_W-1:0] word;
  cwrq_pkg::out_item_t         beat;
  logic [ENT_AW-1:0]           addr_entry;
  logic [BEAT_W-1:0]           addr_k;

  assign cmd_status = cwrq_pkg::status_t'(cmd_data[CMD_W-1 -: cwrq_pkg::STATUS_W]);
  assign cmd_entry  = cmd_data[ENT_AW-1:0];

  always_comb begin
    {cur_cnt, cur_hdr} = {cnt_r, hdr_r};
    if (state_r == cwrq_pkg::BK_FIRST) begin
      {cur_cnt, cur_hdr} = hdr_rdata;
    end
  end

  assign nbytes_raw = cwrq_pkg::dlc_to_bytes(cur_hdr.dlc);
  assign nbytes     = (nbytes_raw > cwrq_pkg::BYTES_W'(MAX_PAYLOAD_BYTES)) ?
                      cwrq_pkg::BYTES_W'(MAX_PAYLOAD_BYTES) : nbytes_raw;
  assign nbeats_w   = (8'(nbytes) + 8'd7) >> 3;
  assign nbeats     = (nbeats_w == 8'd0) ? BIDX_W'(1) : BIDX_W'(nbeats_w);

  always_comb begin
    word = pay_rdata;
    if (BIDX_W'(k_r) >= cur_cnt) begin
      word = '0;
    end
    for (int j = 0; j < 8; j++) begin
      if (8'({k_r, 3'b000}) + 8'(j) >= 8'(nbytes)) begin
        word[j*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    beat.status         = cwrq_pkg::STATUS_OK;
    beat.frame_id       = cur_hdr.id;
    beat.frame_extended = cur_hdr.ext;
    beat.frame_dlc      = cur_hdr.dlc;
    beat.byte_count     = nbytes;
    beat.payload_word   = word;
    beat.result_last    = (BIDX_W'(k_r) + BIDX_W'(1) == nbeats);
  end

  assign addr_entry = (state_r == cwrq_pkg::BK_IDLE) ? cmd_entry : entry_r;
  assign addr_k     = (state_r == cwrq_pkg::BK_IDLE) ? '0 : k_r + 1'b1;
  assign hdr_raddr  = cmd_entry;
  assign pay_raddr  = PAY_AW'(addr_entry) * PAY_AW'(BEATS) + PAY_AW'(addr_k);

  always_comb begin
    state_nxt = state_r;
    entry_nxt = entry_r;
    k_nxt     = k_r;
    hdr_nxt   = hdr_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    cmd_pop   = 1'b0;
    hdr_re    = 1'b0;
    pay_re    = 1'b0;
    case (state_r)
      cwrq_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd_status != cwrq_pkg::STATUS_OK) begin
            out_nxt             = '0;
            out_nxt.status      = cmd_status;
            out_nxt.result_last = 1'b1;
            state_nxt           = cwrq_pkg::BK_OUT;
          end else begin
            hdr_re    = 1'b1;
            pay_re    = 1'b1;
            entry_nxt = cmd_entry;
            k_nxt     = '0;
            state_nxt = cwrq_pkg::BK_FIRST;
          end
        end
      end
      cwrq_pkg::BK_FIRST: begin
        hdr_nxt   = cur_hdr;
        cnt_nxt   = cur_cnt;
        out_nxt   = beat;
        state_nxt = cwrq_pkg::BK_OUT;
      end
      cwrq_pkg::BK_LOAD: begin
        out_nxt   = beat;
        state_nxt = cwrq_pkg::BK_OUT;
      end
      cwrq_pkg::BK_OUT: begin
        if (!out_stall) begin
          if (out_r.result_last) begin
            state_nxt = cwrq_pkg::BK_IDLE;
          end else begin
            pay_re    = 1'b1;
            k_nxt     = k_r + 1'b1;
            state_nxt = cwrq_pkg::BK_LOAD;
          end
        end
      end
      default: state_nxt = cwrq_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cwrq_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    k_r     <= k_nxt;
    hdr_r   <= hdr_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != cwrq_pkg::BK_IDLE) || cmd_valid;
  assign out_valid = (state_r == cwrq_pkg::BK_OUT);
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_r.result_last) |=> state_r == cwrq_pkg::BK_IDLE)
    else $error("Back end did not return to idle after the final beat.");

  a_next_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_r.result_last) |=>
      (state_r == cwrq_pkg::BK_LOAD && k_r == BEAT_W'($past(k_r) + 1'b1)))
    else $error("Beat index did not advance after a non-final transfer.");

  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_r.status != cwrq_pkg::STATUS_OK) |->
      (out_r.result_last && out_r.payload_word == '0 && out_r.byte_count == '0))
    else $error("Status-only result carries frame data or is not final.");

  a_cmd_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cwrq_pkg::BK_IDLE && cmd_valid) |=> state_r != cwrq_pkg::BK_IDLE)
    else $error("Queued pop command was not started.");
`endif

endmodule
